### sv/rgbyuv_pkg.sv
// ----------------------------------------------------------------------------
// rgbyuv_pkg
// Shared types, opcodes, fixed-point coefficients and helpers of the
// BT.601 full-swing color converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbyuv_pkg;

  localparam int OpW = 2;
  localparam int ChW = 8;

  // Operation codes. Bit 1 selects the alpha premultiply.
  localparam logic [OpW-1:0] OP_RGB2YUV     = 2'd0;
  localparam logic [OpW-1:0] OP_YUV2RGB     = 2'd1;
  localparam logic [OpW-1:0] OP_YUV2RGB_PRE = 2'd2;

  // Fixed-point coefficients, unsigned Q1.16 (scaled by 2^16).
  localparam logic [16:0] K_YR = 17'd19595;
  localparam logic [16:0] K_YG = 17'd38470;
  localparam logic [16:0] K_YB = 17'd7471;
  localparam logic [16:0] K_U  = 17'd36962;
  localparam logic [16:0] K_V  = 17'd46727;
  localparam logic [16:0] K_RV = 17'd91881;
  localparam logic [16:0] K_GU = 17'd22544;
  localparam logic [16:0] K_GV = 17'd46793;
  localparam logic [16:0] K_BU = 17'd116129;
  localparam logic signed [11:0] OFS_R = 12'sd179;
  localparam logic signed [11:0] OFS_G = 12'sd135;
  localparam logic signed [11:0] OFS_B = 12'sd226;
  localparam logic signed [11:0] OFS_C = 12'sd128;

  // Load enables of the pipeline registers, one per stage.
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld_out;
  } stage_ld_t;

  // Clamp a signed intermediate to an 8-bit channel.
  function automatic logic [ChW-1:0] clip8(input logic signed [11:0] x);
    logic [ChW-1:0] res;
    if (x < 0) begin
      res = '0;
    end else if (x > 12'sd255) begin
      res = 8'd255;
    end else begin
      res = x[ChW-1:0];
    end
    return res;
  endfunction

  // Exact floor(p / 255) for any p below 65280, where the quotient fits 8 bits.
  function automatic logic [ChW-1:0] div255(input logic [15:0] p);
    logic [16:0] s;
    s = {1'b0, p} + 17'd1 + {9'd0, p[15:8]};
    return s[15:8];
  endfunction

endpackage

`default_nettype wire

### sv/rgbyuv_datapath.sv
// ----------------------------------------------------------------------------
// rgbyuv_datapath
// Payload registers and arithmetic of the four-stage conversion pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbyuv_datapath (
  input  wire logic                    clk,
  input  wire rgbyuv_pkg::stage_ld_t   ld,
  input  wire logic [1:0]              op_in,
  input  wire logic [7:0]              c0_in,
  input  wire logic [7:0]              c1_in,
  input  wire logic [7:0]              c2_in,
  input  wire logic [7:0]              alpha_in,
  output logic [7:0]                   o0,
  output logic [7:0]                   o1,
  output logic [7:0]                   o2
);
  import rgbyuv_pkg::*;

  // Stage 1: first multiplies.
  logic [1:0]  op1_r;
  logic [7:0]  y1_r, r1_r, b1_r, a1_r;
  logic [24:0] pa_r, pb_r, pc_r, pd_r;
  logic        is_rgb_in;

  assign is_rgb_in = (op_in == OP_RGB2YUV);

  always_ff @(posedge clk) begin
    if (ld.ld1) begin
      op1_r <= op_in;
      y1_r  <= c0_in;
      r1_r  <= c0_in;
      b1_r  <= c2_in;
      a1_r  <= alpha_in;
      pa_r  <= is_rgb_in ? 25'(K_YR * c0_in) : 25'(K_RV * c2_in);
      pb_r  <= is_rgb_in ? 25'(K_YG * c1_in) : 25'(K_GU * c1_in);
      pc_r  <= is_rgb_in ? 25'(K_YB * c2_in) : 25'(K_GV * c2_in);
      pd_r  <= 25'(K_BU * c1_in);
    end
  end

  // Stage 2: luma for the forward path, clamped RGB for the inverse path.
  logic [25:0]       sum_y;
  logic [24:0]       sum_g;
  logic signed [11:0] r_s, g_s, b_s;
  logic [1:0]        op2_r;
  logic [7:0]        ch0_r, ch1_r, ch2_r, a2_r;

  always_comb begin
    sum_y = {1'b0, pa_r} + {1'b0, pb_r} + {1'b0, pc_r};
    sum_g = pb_r + pc_r;
    r_s = $signed({4'd0, y1_r}) + $signed({3'd0, pa_r[24:16]}) - OFS_R;
    g_s = $signed({4'd0, y1_r}) - $signed({3'd0, sum_g[24:16]}) + OFS_G;
    b_s = $signed({4'd0, y1_r}) + $signed({3'd0, pd_r[24:16]}) - OFS_B;
  end

  // Forward path keeps Y, B and R; inverse path keeps R, G and B.
  always_ff @(posedge clk) begin
    if (ld.ld2) begin
      op2_r <= op1_r;
      a2_r  <= a1_r;
      if (op1_r == OP_RGB2YUV) begin
        ch0_r <= sum_y[23:16];
        ch1_r <= b1_r;
        ch2_r <= r1_r;
      end else begin
        ch0_r <= clip8(r_s);
        ch1_r <= clip8(g_s);
        ch2_r <= clip8(b_s);
      end
    end
  end

  // Stage 3: chroma multiplies, alpha multiplies, or the channels pass through.
  logic signed [26:0] du, dv;
  logic [1:0]         op3_r;
  logic [7:0]         q0_r;
  logic [15:0]        m0_r;
  logic signed [26:0] m1_r, m2_r;

  assign du = $signed({19'd0, ch1_r}) - $signed({19'd0, ch0_r});
  assign dv = $signed({19'd0, ch2_r}) - $signed({19'd0, ch0_r});

  always_ff @(posedge clk) begin
    if (ld.ld3) begin
      op3_r <= op2_r;
      q0_r  <= ch0_r;
      m0_r  <= 16'(ch0_r * a2_r);
      if (op2_r == OP_RGB2YUV) begin
        m1_r <= du * $signed({10'd0, K_U});
        m2_r <= dv * $signed({10'd0, K_V});
      end else if (op2_r[1]) begin
        m1_r <= $signed({11'd0, 16'(ch1_r * a2_r)});
        m2_r <= $signed({11'd0, 16'(ch2_r * a2_r)});
      end else begin
        m1_r <= $signed({19'd0, ch1_r});
        m2_r <= $signed({19'd0, ch2_r});
      end
    end
  end

  // Stage 4: shift, offset and clamp, divide by 255, or pass through; into the output register.
  logic signed [11:0] u_s, v_s;
  logic [7:0]         n0, n1, n2;

  always_comb begin
    u_s = $signed({m1_r[26], m1_r[26:16]}) + OFS_C;
    v_s = $signed({m2_r[26], m2_r[26:16]}) + OFS_C;
    if (op3_r == OP_RGB2YUV) begin
      n0 = q0_r;
      n1 = clip8(u_s);
      n2 = clip8(v_s);
    end else if (op3_r[1]) begin
      n0 = div255(m0_r);
      n1 = div255(m1_r[15:0]);
      n2 = div255(m2_r[15:0]);
    end else begin
      n0 = q0_r;
      n1 = m1_r[7:0];
      n2 = m2_r[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld.ld_out) begin
      o0 <= n0;
      o1 <= n1;
      o2 <= n2;
    end
  end

endmodule

`default_nettype wire

### sv/rgb_yuv_color_convert_top.sv
// ----------------------------------------------------------------------------
// rgb_yuv_color_convert_top
// Full-swing BT.601 RGB/YUV pixel converter with optional alpha premultiply.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | tdata (low bit up)                  | tuser
//  in_     | slave     | first, second, third comp., alpha   | opcode
//  out_    | master    | out_first, out_second, out_third,   | -
//          |           | packed_color, 48 bits               |
//
//  One pixel enters per clock while in_tready is high. A taken beat passes
//  through three arithmetic stages and then the output register.
//  The throughput is set by the stage-to-stage handshake: each stage loads
//  whenever it is empty or its successor loads, so bubbles collapse.
//  rst_n (synchronous, active low) clears only the stage valid bits.
//  When out_tready is low the pipeline fills and then in_tready drops; no
//  beat is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_yuv_color_convert_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // first_component, second_component, third_component, alpha_value
  input  wire logic [31:0] in_tdata,
  // opcode
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // out_first, out_second, out_third, packed_color
  output logic [47:0]      out_tdata
);
  import rgbyuv_pkg::*;

  // Valid bits of the three arithmetic stages; out_tvalid is the fourth.
  logic      v1_r, v2_r, v3_r, vo_r;
  logic      rdy1, rdy2, rdy3, rdyo;
  stage_ld_t ld;
  logic [7:0] o0, o1, o2;

  // A stage may load when it is empty or its contents move on this cycle.
  assign rdyo = !vo_r || out_tready;
  assign rdy3 = !v3_r || rdyo;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign ld.ld1    = rdy1;
  assign ld.ld2    = rdy2;
  assign ld.ld3    = rdy3;
  assign ld.ld_out = rdyo;

  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_tvalid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdyo) begin
        vo_r <= v3_r;
      end
    end
  end

  rgbyuv_datapath u_datapath (
    .clk      (clk),
    .ld       (ld),
    .op_in    (in_tuser),
    .c0_in    (in_tdata[7:0]),
    .c1_in    (in_tdata[15:8]),
    .c2_in    (in_tdata[23:16]),
    .alpha_in (in_tdata[31:24]),
    .o0       (o0),
    .o1       (o1),
    .o2       (o2)
  );

  assign out_tvalid = vo_r;
  // The packed color repeats the three channels, first channel on top.
  assign out_tdata  = {o0, o1, o2, o2, o1, o0};

endmodule

`default_nettype wire
